>>> hw/rtl/ddpl_pkg.sv
// ----------------------------------------------------------------------------
// ddpl_pkg
// Shared types and constants for the dequantizing dot-product logit block:
// payload structs, configuration register indexes and controller commands.
// ----------------------------------------------------------------------------
package ddpl_pkg;

    localparam int FEAT_IDX_W = 10;
    localparam int VALUE_W    = 16;
    localparam int SCALE_W    = 24;
    localparam int LOGIT_W    = 32;
    localparam int ACC_W      = 48;
    localparam int EMBED_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Operand width of the shared signed multiplier.
    localparam int MUL_W      = 25;
    localparam int PROD_W     = 2 * MUL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMBED_WIDTH = 1'b1;

    localparam logic FUNC_LOAD_HIDDEN  = 1'b0;
    localparam logic FUNC_APPLY_WEIGHT = 1'b1;

    localparam logic [EMBED_W-1:0] EMBED_WIDTH_RESET = 11'd768;

    typedef struct packed {
        logic                        func;
        logic [FEAT_IDX_W-1:0]       feature_index;
        logic signed [VALUE_W-1:0]   hidden_value;
        logic signed [VALUE_W-1:0]   weight_value;
        logic [SCALE_W-1:0]          row_scale;
    } t_in_item;

    typedef struct packed {
        logic signed [LOGIT_W-1:0]   logit;
        logic                        saturated;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic load_in;
        logic calc_idx;
        logic mem_write;
        logic mem_read;
        logic mul_prod;
        logic acc_update;
        logic mul_lo;
        logic mul_hi;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_hidden;
        logic is_last;
        logic quant;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hw/rtl/ddpl_ctrl.sv
// ----------------------------------------------------------------------------
// ddpl_ctrl
// Sequencer that steps one item at a time through index reduction, hidden
// store access, multiply, accumulate and the row-end scaling.
// ----------------------------------------------------------------------------
module ddpl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ddpl_pkg::t_dp_stat i_stat,
    output ddpl_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDX,
        ST_MEM,
        ST_MUL,
        ST_ACC,
        ST_SLO,
        ST_SHI,
        ST_FIN
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_IDX;
                    end
                end
                ST_IDX: begin
                    r_state <= ST_MEM;
                end
                ST_MEM: begin
                    r_state <= i_stat.is_hidden ? ST_IDLE : ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (!i_stat.is_last) begin
                        r_state <= ST_IDLE;
                    end else if (i_stat.quant) begin
                        r_state <= ST_SLO;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_SLO: begin
                    r_state <= ST_SHI;
                end
                ST_SHI: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (i_stat.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load_in    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.calc_idx   = (r_state == ST_IDX);
        o_cmd.mem_write  = (r_state == ST_MEM) && i_stat.is_hidden;
        o_cmd.mem_read   = (r_state == ST_MEM) && !i_stat.is_hidden;
        o_cmd.mul_prod   = (r_state == ST_MUL);
        o_cmd.acc_update = (r_state == ST_ACC);
        o_cmd.mul_lo     = (r_state == ST_SLO);
        o_cmd.mul_hi     = (r_state == ST_SHI);
        o_cmd.load_out   = (r_state == ST_FIN) && i_stat.out_free;
    end

endmodule

>>> hw/rtl/ddpl_dp.sv
// ----------------------------------------------------------------------------
// ddpl_dp
// Datapath: configuration registers, hidden store, shared signed multiplier,
// row accumulator, row-end scaling with saturation and the output register.
// ----------------------------------------------------------------------------
module ddpl_dp #(
    parameter int MAX_FEATURES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ddpl_pkg::t_in_item                 i_in_data,
    input  logic                               i_cfg_valid,
    input  logic [ddpl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ddpl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output ddpl_pkg::t_out_item                o_out_data,
    input  ddpl_pkg::t_dp_cmd                  i_cmd,
    output ddpl_pkg::t_dp_stat                 o_stat
);

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CW = ($clog2(MAX_FEATURES + 1) > ddpl_pkg::EMBED_W) ?
                        $clog2(MAX_FEATURES + 1) : ddpl_pkg::EMBED_W;
    localparam int FW = ddpl_pkg::FEAT_IDX_W;
    localparam int PW = ddpl_pkg::PROD_W;
    localparam int MW = ddpl_pkg::MUL_W;
    localparam int SW = ddpl_pkg::SCALE_W;
    localparam int VW = ddpl_pkg::VALUE_W;

    localparam logic signed [PW-1:0] SAT_HI = PW'(64'sh7FFF_FFFF);
    localparam logic signed [PW-1:0] SAT_LO = PW'(-64'sh8000_0000);

    logic                         r_quant;
    logic [ddpl_pkg::EMBED_W-1:0] r_embed;
    ddpl_pkg::t_in_item           r_in;
    logic [AW-1:0]                r_idx;
    logic [VW-1:0]                r_rd;
    logic signed [PW-1:0]         r_mul;
    logic [ddpl_pkg::ACC_W-1:0]   r_plo;
    logic [ddpl_pkg::ACC_W-1:0]   r_acc;
    logic [ddpl_pkg::ACC_W-1:0]   r_sum;
    logic                         r_out_valid;
    ddpl_pkg::t_out_item          r_out;

    logic [VW-1:0] mem_hidden [MAX_FEATURES];

    logic [CW-1:0]                w_width;
    logic                         w_last;
    logic signed [VW-1:0]         w_wt;
    logic signed [MW-1:0]         w_ma;
    logic signed [MW-1:0]         w_mb;
    logic signed [PW-1:0]         w_prod;
    logic [ddpl_pkg::ACC_W-1:0]   w_sum;
    logic signed [PW-1:0]         w_res;
    ddpl_pkg::t_out_item          n_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant <= 1'b0;
            r_embed <= ddpl_pkg::EMBED_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ddpl_pkg::CFG_QUANT_MODE: begin
                    r_quant <= i_cfg_data[0];
                end
                ddpl_pkg::CFG_EMBED_WIDTH: begin
                    r_embed <= i_cfg_data[ddpl_pkg::EMBED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
    end

    // The feature index wraps modulo the store depth. Below 1024 entries this
    // is a multiply by a rounded-up reciprocal, exact for all 10-bit indexes,
    // followed by a multiply-back and subtract in the next step.
    generate
        if (MAX_FEATURES >= (1 << FW)) begin : g_idx_direct
            always_ff @(posedge i_clk) begin
                if (i_cmd.calc_idx) begin
                    r_idx <= AW'(r_in.feature_index);
                end
            end
        end else begin : g_idx_mod
            localparam int SH = FW + $clog2(MAX_FEATURES);
            localparam int RW = SH + 1;
            localparam logic [RW-1:0] RECIP =
                RW'((2 ** SH + MAX_FEATURES - 1) / MAX_FEATURES);

            logic [FW+RW-1:0] w_qprod;
            logic [2*FW-1:0]  w_qm;
            logic [2*FW-1:0]  w_rem;
            logic [FW-1:0]    r_q;

            assign w_qprod = (FW + RW)'(i_in_data.feature_index) * (FW + RW)'(RECIP);
            assign w_qm    = (2 * FW)'(r_q) * (2 * FW)'(MAX_FEATURES);
            assign w_rem   = (2 * FW)'(r_in.feature_index) - w_qm;

            always_ff @(posedge i_clk) begin
                if (i_cmd.load_in) begin
                    r_q <= w_qprod[SH +: FW];
                end
                if (i_cmd.calc_idx) begin
                    r_idx <= w_rem[AW-1:0];
                end
            end
        end
    endgenerate

    // Hidden store, single port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            mem_hidden[r_idx] <= r_in.hidden_value;
        end
        if (i_cmd.mem_read) begin
            r_rd <= mem_hidden[r_idx];
        end
    end

    // Effective row width, clamped to 1..MAX_FEATURES.
    always_comb begin
        w_width = (r_embed == '0) ? CW'(1) : CW'(r_embed);
        if (w_width > CW'(MAX_FEATURES)) begin
            w_width = CW'(MAX_FEATURES);
        end
    end

    assign w_last = (CW'(r_idx) == (w_width - CW'(1)));

    assign w_wt = r_quant ?
                  {{8{r_in.weight_value[7]}}, r_in.weight_value[7:0]} :
                  r_in.weight_value;

    // One shared multiplier: weight products, then the two halves of the
    // row sum times the scale.
    always_comb begin
        if (i_cmd.mul_lo) begin
            w_ma = {1'b0, r_sum[SW-1:0]};
            w_mb = {1'b0, r_in.row_scale};
        end else if (i_cmd.mul_hi) begin
            w_ma = {r_sum[ddpl_pkg::ACC_W-1], r_sum[ddpl_pkg::ACC_W-1:SW]};
            w_mb = {1'b0, r_in.row_scale};
        end else begin
            w_ma = {{(MW - VW){r_rd[VW-1]}}, r_rd};
            w_mb = {{(MW - VW){w_wt[VW-1]}}, w_wt};
        end
    end

    assign w_prod = w_ma * w_mb;
    assign w_sum  = r_acc + r_mul[ddpl_pkg::ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_prod || i_cmd.mul_hi) begin
            r_mul <= w_prod;
        end
        if (i_cmd.mul_lo) begin
            r_plo <= w_prod[ddpl_pkg::ACC_W-1:0];
        end
        if (i_cmd.acc_update && w_last) begin
            r_sum <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.acc_update) begin
            r_acc <= w_last ? '0 : w_sum;
        end
    end

    // Row-end result: floor of sum*scale/2^24 as hi*scale plus the carry of
    // lo*scale, or the sum shifted down by 14 in plain mode.
    always_comb begin
        if (r_quant) begin
            w_res = r_mul + $signed({(PW - SW)'(0), r_plo[ddpl_pkg::ACC_W-1:SW]});
        end else begin
            w_res = $signed({{16{r_sum[ddpl_pkg::ACC_W-1]}}, r_sum[ddpl_pkg::ACC_W-1:14]});
        end
        n_out.saturated = 1'b1;
        if (w_res > SAT_HI) begin
            n_out.logit = SAT_HI[ddpl_pkg::LOGIT_W-1:0];
        end else if (w_res < SAT_LO) begin
            n_out.logit = SAT_LO[ddpl_pkg::LOGIT_W-1:0];
        end else begin
            n_out.logit     = w_res[ddpl_pkg::LOGIT_W-1:0];
            n_out.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.is_hidden = (r_in.func == ddpl_pkg::FUNC_LOAD_HIDDEN);
    assign o_stat.is_last   = w_last;
    assign o_stat.quant     = r_quant;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

>>> hw/rtl/dequant_dot_product_logits.sv
// ----------------------------------------------------------------------------
// dequant_dot_product_logits
// Matrix-vector product of weight rows with a stored hidden vector, giving
// one saturated 32-bit logit per row, in int8-with-scale or Q2.14 mode.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A hidden-element load steps through index
// wrap and one single-port hidden store access; a weight element adds one
// pass through the shared 25x25 multiplier and the accumulate. The beat that
// ends a row adds the output load in plain mode and, in int8 mode, first the
// two halves of sum times scale on the same multiplier; the finished logit
// may wait for the output register to empty. The output register lets the
// next item start while a logit waits to be taken. The hidden store is not
// cleared at reset; each entry must be loaded before a row reads it.
// Configuration writes are always accepted.
module dequant_dot_product_logits #(
    parameter int MAX_FEATURES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ddpl_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ddpl_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ddpl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ddpl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    ddpl_pkg::t_dp_cmd  w_cmd;
    ddpl_pkg::t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    ddpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ddpl_dp #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

>>> hw/rtl/ddpl_chk.sv
// ----------------------------------------------------------------------------
// ddpl_chk
// Port-level checks on the logit block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ddpl_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input ddpl_pkg::t_in_item                 i_in_data,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input ddpl_pkg::t_out_item                o_out_data,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [ddpl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [ddpl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // A stalled result beat keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Items are taken one at a time, so ready drops after each input beat.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after an accepted beat");

    // A logit is never raised directly after an accepted input beat.
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready))
        else $error("result appeared directly after an input beat");

    // A clipped logit sits exactly at one of the 32-bit limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            (o_out_data.logit == 32'sh7FFF_FFFF) ||
            (o_out_data.logit == -32'sh8000_0000))
        else $error("saturated logit is not at a limit");

    // Configuration writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write was stalled");

endmodule

bind dequant_dot_product_logits ddpl_chk u_ddpl_chk (.*);

>>> test/dequant_dot_product_logits_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dequant_dot_product_logits_tb
// Loads hidden vectors and streams weight rows through the logit block in
// plain and int8 modes, including width clamping and logit saturation.
// Every logit is checked against a cycle-free predictor of the row sum,
// with and without random stalls on both streams.
// ----------------------------------------------------------------------------
module dequant_dot_product_logits_tb;

    localparam int MAX_FEAT = 1024;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    ddpl_pkg::t_in_item              i_in_data = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    ddpl_pkg::t_out_item             o_out_data;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [ddpl_pkg::CFG_IDX_W-1:0]  i_cfg_index = ddpl_pkg::CFG_QUANT_MODE;
    logic [ddpl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state.
    logic signed [ddpl_pkg::VALUE_W-1:0] hid_mem [0:MAX_FEAT-1];
    bit                                  hid_written [0:MAX_FEAT-1];
    logic [ddpl_pkg::ACC_W-1:0]          row_sum = '0;
    logic                                cfg_quant = 1'b0;
    logic [ddpl_pkg::EMBED_W-1:0]        cfg_width = ddpl_pkg::EMBED_WIDTH_RESET;
    ddpl_pkg::t_out_item                 logits_expected [$];

    int fail_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    dequant_dot_product_logits #(
        .MAX_FEATURES(MAX_FEAT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("dequant_dot_product_logits_tb: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_logits
        ddpl_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (logits_expected.size() == 0) begin
                $display("%0t: unexpected logit beat: expected none, got %0d (sat %0b)",
                         $time, o_out_data.logit, o_out_data.saturated);
                fail_count++;
            end else begin
                want = logits_expected.pop_front();
                if (o_out_data.logit !== want.logit) begin
                    $display("%0t: logit mismatch: expected %0d, got %0d",
                             $time, want.logit, o_out_data.logit);
                    fail_count++;
                end
                if (o_out_data.saturated !== want.saturated) begin
                    $display("%0t: saturated mismatch: expected %0b, got %0b",
                             $time, want.saturated, o_out_data.saturated);
                    fail_count++;
                end
            end
        end
    end

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_FEAT) return MAX_FEAT;
        return int'(cfg_width);
    endfunction

    // Applies one accepted input beat to the predictor and queues the logit
    // when the beat closes a row.
    function automatic void predict_logit(input ddpl_pkg::t_in_item it);
        logic signed [ddpl_pkg::VALUE_W-1:0] wt;
        logic signed [ddpl_pkg::ACC_W-1:0]   prod;
        logic signed [79:0]                  wide;
        ddpl_pkg::t_out_item                 want;
        if (it.func == ddpl_pkg::FUNC_LOAD_HIDDEN) begin
            hid_mem[it.feature_index] = it.hidden_value;
            hid_written[it.feature_index] = 1'b1;
            return;
        end
        if (cfg_quant)
            wt = $signed(it.weight_value[7:0]);
        else
            wt = it.weight_value;
        prod = hid_mem[it.feature_index] * wt;
        row_sum = row_sum + prod;
        if (int'(it.feature_index) != eff_width() - 1) return;
        // Both paths floor toward minus infinity.
        if (cfg_quant)
            wide = ($signed(row_sum) * $signed({1'b0, it.row_scale})) >>> 24;
        else
            wide = $signed(row_sum) >>> 14;
        want.saturated = 1'b1;
        if (wide > 80'sd2147483647)
            want.logit = 32'sh7FFF_FFFF;
        else if (wide < -80'sd2147483648)
            want.logit = 32'sh8000_0000;
        else begin
            want.logit = wide[ddpl_pkg::LOGIT_W-1:0];
            want.saturated = 1'b0;
        end
        logits_expected.push_back(want);
        row_sum = '0;
    endfunction

    function automatic logic signed [ddpl_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(19))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return ddpl_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [ddpl_pkg::SCALE_W-1:0] rand_scale();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return ddpl_pkg::SCALE_W'($urandom);
        endcase
    endfunction

    // Valid stays high between back-to-back beats; it only drops in an idle gap.
    task automatic send_item(input ddpl_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_logit(it);
        items_sent++;
    endtask

    task automatic send_hidden(input int idx,
                               input logic signed [ddpl_pkg::VALUE_W-1:0] value);
        ddpl_pkg::t_in_item it;
        it.func = ddpl_pkg::FUNC_LOAD_HIDDEN;
        it.feature_index = ddpl_pkg::FEAT_IDX_W'(idx);
        it.hidden_value = value;
        it.weight_value = ddpl_pkg::VALUE_W'($urandom);
        it.row_scale = ddpl_pkg::SCALE_W'($urandom);
        send_item(it);
    endtask

    // Loads the hidden entry first if it has never been written.
    task automatic send_weight(input int idx,
                               input logic signed [ddpl_pkg::VALUE_W-1:0] w,
                               input logic [ddpl_pkg::SCALE_W-1:0] scale);
        ddpl_pkg::t_in_item it;
        if (!hid_written[idx]) send_hidden(idx, rand_value());
        it.func = ddpl_pkg::FUNC_APPLY_WEIGHT;
        it.feature_index = ddpl_pkg::FEAT_IDX_W'(idx);
        it.hidden_value = ddpl_pkg::VALUE_W'($urandom);
        it.weight_value = w;
        it.row_scale = scale;
        send_item(it);
    endtask

    // Waits until the block has drained, then idles so that any beat still in flight finishes.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (logits_expected.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic configure(input logic quant,
                             input logic [ddpl_pkg::EMBED_W-1:0] width);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ddpl_pkg::CFG_QUANT_MODE;
        i_cfg_data <= ddpl_pkg::CFG_DATA_W'(quant);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_quant = quant;
        i_cfg_index <= ddpl_pkg::CFG_EMBED_WIDTH;
        i_cfg_data <= width;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_width = width;
        i_cfg_valid <= 1'b0;
    endtask

    // Rows under the reset configuration: plain mode, 768 features.
    task automatic test_reset_config();
        send_hidden(0, 16'sh0400);
        send_hidden(767, 16'shFC00);
        send_weight(0, 16'sh4000, '1);
        send_weight(767, 16'sh8000, '0);
        settle();
    endtask

    task automatic test_plain_extremes();
        configure(1'b0, 11'd4);
        send_hidden(0, 16'sh8000);
        send_hidden(1, 16'sh7FFF);
        send_hidden(2, 16'sh0000);
        send_hidden(3, 16'shFFFF);
        send_weight(0, 16'sh8000, '0);
        send_weight(1, 16'sh7FFF, '1);
        send_weight(2, 16'sh5555, 24'hAAAAAA);
        send_weight(3, 16'shFFFF, 24'h555555);
        settle();
    endtask

    // A zero width counts as one feature, anything above the store as the full store.
    task automatic test_width_limits();
        configure(1'b0, 11'd0);
        send_weight(2, 16'sh1234, '0);
        send_weight(0, 16'shC000, '0);
        settle();
        configure(1'b1, 11'd2047);
        send_hidden(1023, 16'sh7FFF);
        send_weight(1023, 16'sh337F, '1);
        settle();
        configure(1'b1, 11'd1);
        send_weight(0, 16'shA581, '0);
        settle();
    endtask

    // Builds a large row sum with plain products, which are far wider than
    // int8 ones, then closes the row in int8 mode at full scale.
    task automatic test_saturation();
        configure(1'b0, 11'd8);
        send_hidden(4, 16'sh8000);
        repeat (4) send_weight(4, 16'sh8000, '0);
        settle();
        configure(1'b1, 11'd5);
        send_weight(4, 16'shA57F, '1);
        settle();
        configure(1'b0, 11'd8);
        repeat (4) send_weight(4, 16'sh7FFF, '0);
        settle();
        configure(1'b1, 11'd5);
        send_weight(4, 16'sh3C80, '1);
        settle();
    endtask

    function automatic logic [ddpl_pkg::EMBED_W-1:0] rand_width();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return ddpl_pkg::EMBED_W'($urandom_range(1, 12));
        if (sel < 78) return ddpl_pkg::EMBED_W'($urandom_range(0, 1));
        if (sel < 84) return ddpl_pkg::EMBED_W'(MAX_FEAT);
        if (sel < 90) return ddpl_pkg::EMBED_W'($urandom_range(MAX_FEAT + 1, 2047));
        return ddpl_pkg::EMBED_W'($urandom_range(13, MAX_FEAT - 1));
    endfunction

    // Long rows are sent as their last few features only.
    task automatic send_row();
        int ew;
        int first;
        ew = eff_width();
        first = (ew > 16) ? ew - int'($urandom_range(1, 6)) : 0;
        for (int f = first; f < ew; f++) begin
            if ($urandom_range(9) == 0) send_hidden(f, rand_value());
            send_weight(f, rand_value(), rand_scale());
        end
    endtask

    task automatic test_random_rows(input int n_items);
        int stop_at;
        int sel;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            settle();
            configure(1'($urandom), rand_width());
            repeat ($urandom_range(3, 8)) begin
                sel = $urandom_range(99);
                if (sel < 70)
                    send_row();
                else if (sel < 85)
                    repeat ($urandom_range(1, 6))
                        send_hidden($urandom_range(MAX_FEAT - 1), rand_value());
                else
                    repeat ($urandom_range(1, 5))
                        send_weight($urandom_range(MAX_FEAT - 1), rand_value(), rand_scale());
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 15;
        recv_idle_pct = 75;
        test_reset_config();
        test_plain_extremes();
        test_width_limits();
        test_saturation();
        test_random_rows(300);
        send_idle_pct = 75;
        recv_idle_pct = 15;
        test_random_rows(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_rows(300);
        settle();
        if (fail_count == 0)
            $display("dequant_dot_product_logits_tb: PASS");
        else
            $display("dequant_dot_product_logits_tb: FAIL");
        $finish;
    end

endmodule
